// ----- hdl/kfli_pkg.sv -----
// shared types and constants of the keyframe linear motion interpolator
package kfli_pkg;

    // field widths
    localparam int TICK_W    = 32;
    localparam int POS_W     = 16;
    localparam int DIFF_W    = POS_W + 1;
    localparam int PROD_W    = 48;
    localparam int DIV_CNT_W = 6;
    localparam int ACT_W     = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;

    // action codes of an input word
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd0;
    localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_QUERY = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Y = 2'd1;

    // result status codes
    localparam logic STS_OK   = 1'b0;
    localparam logic STS_FULL = 1'b1;

    // one keyframe as stored in the table memory
    typedef struct packed {
        logic [TICK_W-1:0]       start;
        logic [TICK_W-1:0]       dur;
        logic signed [POS_W-1:0] tx;
        logic signed [POS_W-1:0] ty;
    } t_key;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_LD_RD,
        ST_LD_CMP,
        ST_Q_RD,
        ST_Q_CHK,
        ST_Q_MUL,
        ST_Q_DIV,
        ST_Q_WAIT,
        ST_OUT,
        ST_OUT_FULL,
        ST_OUT_POS
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic clear_count;
        logic ld_init;
        logic qry_init;
        logic rd_prev;
        logic rd_cur;
        logic wr_shift;
        logic wr_new;
        logic snap;
        logic diff_load;
        logic mul_load;
        logic div_start;
        logic lerp_load;
        logic out_load;
        logic out_full;
        logic out_pos;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic [ACT_W-1:0] act;
        logic             full;
        logic             idx_zero;
        logic             idx_end;
        logic             key_gt;
        logic             key_late;
        logic             key_snap;
        logic             div_done;
    } t_sts;

endpackage

// ----- hdl/kfli_ram.sv -----
// generic simple dual port ram with registered read
module kfli_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/kfli_div.sv -----
// iterative restoring divider, one quotient bit a cycle, signed result
module kfli_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [kfli_pkg::PROD_W-1:0]         i_dividend,
    input  logic                                i_neg,
    input  logic [kfli_pkg::TICK_W-1:0]         i_divisor,
    output logic                                o_done,
    output logic signed [kfli_pkg::DIFF_W-1:0]  o_quot
);

    localparam logic [kfli_pkg::DIV_CNT_W-1:0] LAST_STEP =
        kfli_pkg::DIV_CNT_W'(kfli_pkg::PROD_W - 1);

    logic                                r_busy;
    logic                                r_done;
    logic [kfli_pkg::DIV_CNT_W-1:0]      r_cnt;
    logic [kfli_pkg::TICK_W-1:0]         r_rem;
    logic [kfli_pkg::PROD_W-1:0]         r_dq;
    logic [kfli_pkg::TICK_W-1:0]         r_dvs;
    logic                                r_neg;

    logic [kfli_pkg::TICK_W:0]           w_rem_sh;
    logic [kfli_pkg::TICK_W:0]           w_sub;
    logic                                w_ge;
    logic [kfli_pkg::DIFF_W-1:0]         w_mag;

    // one restoring step
    assign w_rem_sh = {r_rem, r_dq[kfli_pkg::PROD_W-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_dvs});
    assign w_sub    = w_rem_sh - {1'b0, r_dvs};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == LAST_STEP) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dq  <= i_dividend;
            r_dvs <= i_divisor;
            r_neg <= i_neg;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_sub[kfli_pkg::TICK_W-1:0] : w_rem_sh[kfli_pkg::TICK_W-1:0];
            r_dq  <= {r_dq[kfli_pkg::PROD_W-2:0], w_ge};
        end
    end

    // magnitude stays below 2^16, apply sign
    assign w_mag  = {1'b0, r_dq[kfli_pkg::POS_W-1:0]};
    assign o_quot = r_neg ? $signed(-w_mag) : $signed(w_mag);
    assign o_done = r_done;

endmodule

// ----- hdl/kfli_dp.sv -----
// datapath: keyframe table, walk registers, multipliers, dividers, result word
module kfli_dp #(
    parameter int MAX_KEYS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  kfli_pkg::t_cmd                       i_cmd,
    output kfli_pkg::t_sts                       o_sts,
    input  logic                                 i_cfg_valid,
    input  logic [kfli_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [kfli_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic [kfli_pkg::ACT_W-1:0]           i_action,
    input  logic [kfli_pkg::TICK_W-1:0]          i_key_start,
    input  logic [kfli_pkg::TICK_W-1:0]          i_key_duration,
    input  logic signed [kfli_pkg::POS_W-1:0]    i_target_x,
    input  logic signed [kfli_pkg::POS_W-1:0]    i_target_y,
    input  logic [kfli_pkg::TICK_W-1:0]          i_query_tick,
    output logic                                 o_status,
    output logic signed [kfli_pkg::POS_W-1:0]    o_pos_x,
    output logic signed [kfli_pkg::POS_W-1:0]    o_pos_y
);

    localparam int IW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CW = $clog2(MAX_KEYS + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_KEYS);
    localparam int TW = kfli_pkg::TICK_W;
    localparam int PW = kfli_pkg::POS_W;
    localparam int DW = kfli_pkg::DIFF_W;
    localparam int MW = kfli_pkg::PROD_W;

    // captured input word
    logic [kfli_pkg::ACT_W-1:0]  r_act;
    logic [TW-1:0]               r_ks;
    logic [TW-1:0]               r_kd;
    logic signed [PW-1:0]        r_tx;
    logic signed [PW-1:0]        r_ty;
    logic [TW-1:0]               r_tick;

    // table bookkeeping and walk state
    logic [CW-1:0]               r_count;
    logic [CW-1:0]               r_idx;
    logic [CW-1:0]               n_idx_prev;
    logic signed [PW-1:0]        r_px;
    logic signed [PW-1:0]        r_py;
    logic signed [PW-1:0]        r_start_x;
    logic signed [PW-1:0]        r_start_y;

    // interpolation pipeline
    logic signed [DW-1:0]        r_diff_x;
    logic signed [DW-1:0]        r_diff_y;
    logic [TW-1:0]               r_elapsed;
    logic signed [MW:0]          r_prod_x;
    logic signed [MW:0]          r_prod_y;
    logic signed [MW+1:0]        w_mul_x;
    logic signed [MW+1:0]        w_mul_y;
    logic [MW:0]                 w_abs_x;
    logic [MW:0]                 w_abs_y;
    logic signed [DW-1:0]        w_q_x;
    logic signed [DW-1:0]        w_q_y;
    logic                        w_done_x;
    logic                        w_done_y;

    // memory ports
    kfli_pkg::t_key              w_rd;
    kfli_pkg::t_key              w_wdata;
    logic [$bits(kfli_pkg::t_key)-1:0] w_rdata_raw;
    logic [IW-1:0]               w_raddr;
    logic [TW:0]                 w_end;

    // result word
    logic                        r_out_status;
    logic signed [PW-1:0]        r_out_x;
    logic signed [PW-1:0]        r_out_y;

    // keyframe table
    assign n_idx_prev = r_idx - 1'b1;
    assign w_raddr    = i_cmd.rd_prev ? n_idx_prev[IW-1:0] : r_idx[IW-1:0];
    assign w_wdata    = i_cmd.wr_shift ? w_rd : kfli_pkg::t_key'{r_ks, r_kd, r_tx, r_ty};
    assign w_rd       = kfli_pkg::t_key'(w_rdata_raw);

    kfli_ram #(
        .WIDTH ($bits(kfli_pkg::t_key)),
        .DEPTH (MAX_KEYS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_shift | i_cmd.wr_new),
        .i_waddr (r_idx[IW-1:0]),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.rd_prev | i_cmd.rd_cur),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata_raw)
    );

    // capture of the accepted input word
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_act  <= i_action;
            r_ks   <= i_key_start;
            r_kd   <= i_key_duration;
            r_tx   <= i_target_x;
            r_ty   <= i_target_y;
            r_tick <= i_query_tick;
        end
    end

    // start point registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x <= '0;
            r_start_y <= '0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == kfli_pkg::CFG_START_X) begin
                r_start_x <= i_cfg_data;
            end
            if (i_cfg_index == kfli_pkg::CFG_START_Y) begin
                r_start_y <= i_cfg_data;
            end
        end
    end

    // keyframe count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.clear_count) begin
            r_count <= '0;
        end else if (i_cmd.wr_new) begin
            r_count <= r_count + 1'b1;
        end
    end

    // walk index: insertion slot on load, keyframe number on query
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_init) begin
            r_idx <= r_count;
        end else if (i_cmd.qry_init) begin
            r_idx <= '0;
        end else if (i_cmd.wr_shift) begin
            r_idx <= n_idx_prev;
        end else if (i_cmd.snap || i_cmd.lerp_load) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    // current point
    always_ff @(posedge i_clk) begin
        if (i_cmd.qry_init) begin
            r_px <= r_start_x;
            r_py <= r_start_y;
        end else if (i_cmd.snap) begin
            r_px <= w_rd.tx;
            r_py <= w_rd.ty;
        end else if (i_cmd.lerp_load) begin
            r_px <= PW'(r_px + w_q_x[PW-1:0]);
            r_py <= PW'(r_py + w_q_y[PW-1:0]);
        end
    end

    // interpolation: span and elapsed time, then products
    always_ff @(posedge i_clk) begin
        if (i_cmd.diff_load) begin
            r_diff_x  <= {w_rd.tx[PW-1], w_rd.tx} - {r_px[PW-1], r_px};
            r_diff_y  <= {w_rd.ty[PW-1], w_rd.ty} - {r_py[PW-1], r_py};
            r_elapsed <= r_tick - w_rd.start;
        end
        if (i_cmd.mul_load) begin
            r_prod_x <= w_mul_x[MW:0];
            r_prod_y <= w_mul_y[MW:0];
        end
    end

    assign w_mul_x = r_diff_x * $signed({1'b0, r_elapsed});
    assign w_mul_y = r_diff_y * $signed({1'b0, r_elapsed});
    assign w_abs_x = r_prod_x[MW] ? $unsigned(-r_prod_x) : $unsigned(r_prod_x);
    assign w_abs_y = r_prod_y[MW] ? $unsigned(-r_prod_y) : $unsigned(r_prod_y);

    // quotient per axis, truncated toward zero
    kfli_div u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_abs_x[MW-1:0]),
        .i_neg      (r_prod_x[MW]),
        .i_divisor  (w_rd.dur),
        .o_done     (w_done_x),
        .o_quot     (w_q_x)
    );

    kfli_div u_div_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_abs_y[MW-1:0]),
        .i_neg      (r_prod_y[MW]),
        .i_divisor  (w_rd.dur),
        .o_done     (w_done_y),
        .o_quot     (w_q_y)
    );

    // result word register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= i_cmd.out_full ? kfli_pkg::STS_FULL : kfli_pkg::STS_OK;
            r_out_x      <= i_cmd.out_pos ? r_px : '0;
            r_out_y      <= i_cmd.out_pos ? r_py : '0;
        end
    end

    assign o_status = r_out_status;
    assign o_pos_x  = r_out_x;
    assign o_pos_y  = r_out_y;

    // status toward the controller
    assign w_end = {1'b0, w_rd.start} + {1'b0, w_rd.dur};

    always_comb begin
        o_sts          = '0;
        o_sts.act      = r_act;
        o_sts.full     = (r_count >= FULL_COUNT);
        o_sts.idx_zero = (r_idx == '0);
        o_sts.idx_end  = (r_idx >= r_count);
        o_sts.key_gt   = (w_rd.start > r_ks);
        o_sts.key_late = (w_rd.start > r_tick);
        o_sts.key_snap = ({1'b0, r_tick} >= w_end) || (w_rd.dur == '0);
        o_sts.div_done = w_done_x & w_done_y;
    end

endmodule

// ----- hdl/kfli_ctrl.sv -----
// controller: sequences clear, sorted insert and query walk
module kfli_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  kfli_pkg::t_sts  i_sts,
    output kfli_pkg::t_cmd  o_cmd
);

    kfli_pkg::t_state r_state;
    kfli_pkg::t_state n_state;
    logic             r_out_valid;
    logic             w_slot_free;

    // output register can take a new word
    assign w_slot_free = !r_out_valid || i_out_ready;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kfli_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // output word valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            kfli_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = kfli_pkg::ST_DISPATCH;
                end
            end
            kfli_pkg::ST_DISPATCH: begin
                unique case (i_sts.act)
                    kfli_pkg::ACT_CLEAR: begin
                        o_cmd.clear_count = 1'b1;
                        n_state           = kfli_pkg::ST_OUT;
                    end
                    kfli_pkg::ACT_LOAD: begin
                        if (i_sts.full) begin
                            n_state = kfli_pkg::ST_OUT_FULL;
                        end else begin
                            o_cmd.ld_init = 1'b1;
                            n_state       = kfli_pkg::ST_LD_RD;
                        end
                    end
                    kfli_pkg::ACT_QUERY: begin
                        o_cmd.qry_init = 1'b1;
                        n_state        = kfli_pkg::ST_Q_RD;
                    end
                    default: begin
                        n_state = kfli_pkg::ST_OUT;
                    end
                endcase
            end
            // sorted insert: move later keyframes up one slot
            kfli_pkg::ST_LD_RD: begin
                if (i_sts.idx_zero) begin
                    o_cmd.wr_new = 1'b1;
                    n_state      = kfli_pkg::ST_OUT;
                end else begin
                    o_cmd.rd_prev = 1'b1;
                    n_state       = kfli_pkg::ST_LD_CMP;
                end
            end
            kfli_pkg::ST_LD_CMP: begin
                if (i_sts.key_gt) begin
                    o_cmd.wr_shift = 1'b1;
                    n_state        = kfli_pkg::ST_LD_RD;
                end else begin
                    o_cmd.wr_new = 1'b1;
                    n_state      = kfli_pkg::ST_OUT;
                end
            end
            // query walk over keyframes in start order
            kfli_pkg::ST_Q_RD: begin
                if (i_sts.idx_end) begin
                    n_state = kfli_pkg::ST_OUT_POS;
                end else begin
                    o_cmd.rd_cur = 1'b1;
                    n_state      = kfli_pkg::ST_Q_CHK;
                end
            end
            kfli_pkg::ST_Q_CHK: begin
                if (i_sts.key_late) begin
                    n_state = kfli_pkg::ST_OUT_POS;
                end else if (i_sts.key_snap) begin
                    o_cmd.snap = 1'b1;
                    n_state    = kfli_pkg::ST_Q_RD;
                end else begin
                    o_cmd.diff_load = 1'b1;
                    n_state         = kfli_pkg::ST_Q_MUL;
                end
            end
            kfli_pkg::ST_Q_MUL: begin
                o_cmd.mul_load = 1'b1;
                n_state        = kfli_pkg::ST_Q_DIV;
            end
            kfli_pkg::ST_Q_DIV: begin
                o_cmd.div_start = 1'b1;
                n_state         = kfli_pkg::ST_Q_WAIT;
            end
            kfli_pkg::ST_Q_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.lerp_load = 1'b1;
                    n_state         = kfli_pkg::ST_Q_RD;
                end
            end
            // hand the result word to the output register
            kfli_pkg::ST_OUT: begin
                if (w_slot_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = kfli_pkg::ST_IDLE;
                end
            end
            kfli_pkg::ST_OUT_FULL: begin
                if (w_slot_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_full = 1'b1;
                    n_state        = kfli_pkg::ST_IDLE;
                end
            end
            kfli_pkg::ST_OUT_POS: begin
                if (w_slot_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_pos  = 1'b1;
                    n_state        = kfli_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = kfli_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- hdl/keyframe_linear_motion_interpolator.sv -----
// top level of the keyframe linear motion interpolator
// Input channel (i_in_valid/o_in_ready) takes one word: clear the table, load a
// keyframe (kept sorted by start tick, equal starts in load order) or query the
// point at a tick. Output channel (o_out_valid/i_out_ready) returns one word per
// input word: status, and for a query the interpolated x and y.
// Config channel (i_cfg_valid/o_cfg_ready) sets the start point; it is always
// ready. The user must write it only while the block is idle; the block does not check.
// One word is worked on at a time, from the input handshake to the result word
// in the output register. Clear, nop and a load into a full table go from
// dispatch straight to the output step. A load walks down from the end of the
// table, moving each later keyframe up one slot for the sorted insert, then
// writes the new one. A query walks the keyframes in start order: it steps past
// finished ones, stops at a later keyframe, and for each keyframe in progress
// runs the multiply and the 48-step bit-serial divider per axis (both in parallel).
// The next input word is accepted in the cycle after the result is loaded, also
// while that result still waits in the output register; a stalled receiver holds
// the result and only the hand-off of the following word waits.
// Reset empties the table and sets the start point to zero; table contents are
// not cleared, only the keyframe count.
module keyframe_linear_motion_interpolator #(
    parameter int MAX_KEYS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [kfli_pkg::ACT_W-1:0]           i_action,
    input  logic [kfli_pkg::TICK_W-1:0]          i_key_start,
    input  logic [kfli_pkg::TICK_W-1:0]          i_key_duration,
    input  logic signed [kfli_pkg::POS_W-1:0]    i_target_x,
    input  logic signed [kfli_pkg::POS_W-1:0]    i_target_y,
    input  logic [kfli_pkg::TICK_W-1:0]          i_query_tick,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic                                 o_status,
    output logic signed [kfli_pkg::POS_W-1:0]    o_pos_x,
    output logic signed [kfli_pkg::POS_W-1:0]    o_pos_y,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [kfli_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [kfli_pkg::CFG_W-1:0]           i_cfg_data
);

    kfli_pkg::t_cmd w_cmd;
    kfli_pkg::t_sts w_sts;

    // config writes are always accepted
    assign o_cfg_ready = 1'b1;

    // sequencer
    kfli_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // table, arithmetic and result word
    kfli_dp #(
        .MAX_KEYS (MAX_KEYS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_action       (i_action),
        .i_key_start    (i_key_start),
        .i_key_duration (i_key_duration),
        .i_target_x     (i_target_x),
        .i_target_y     (i_target_y),
        .i_query_tick   (i_query_tick),
        .o_status       (o_status),
        .o_pos_x        (o_pos_x),
        .o_pos_y        (o_pos_y)
    );

endmodule

// ----- bench/tb_keyframe_linear_motion_interpolator.sv -----
// self-checking testbench for the keyframe linear motion interpolator
module tb_keyframe_linear_motion_interpolator;

    localparam int KEY_SLOTS = 16;
    localparam logic [kfli_pkg::ACT_W-1:0] ACT_NOP = 2'd3;
    localparam logic [kfli_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;
    localparam int RANDOM_WORDS_PER_PHASE = 470;

    // one input word and one result word
    typedef struct packed {
        logic [kfli_pkg::ACT_W-1:0]        action;
        logic [kfli_pkg::TICK_W-1:0]       key_start;
        logic [kfli_pkg::TICK_W-1:0]       key_duration;
        logic signed [kfli_pkg::POS_W-1:0] target_x;
        logic signed [kfli_pkg::POS_W-1:0] target_y;
        logic [kfli_pkg::TICK_W-1:0]       query_tick;
    } t_move_word;

    typedef struct packed {
        logic                              status;
        logic signed [kfli_pkg::POS_W-1:0] pos_x;
        logic signed [kfli_pkg::POS_W-1:0] pos_y;
    } t_pos_word;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_in_valid = 1'b0;
    logic                              o_in_ready;
    logic [kfli_pkg::ACT_W-1:0]        i_action = '0;
    logic [kfli_pkg::TICK_W-1:0]       i_key_start = '0;
    logic [kfli_pkg::TICK_W-1:0]       i_key_duration = '0;
    logic signed [kfli_pkg::POS_W-1:0] i_target_x = '0;
    logic signed [kfli_pkg::POS_W-1:0] i_target_y = '0;
    logic [kfli_pkg::TICK_W-1:0]       i_query_tick = '0;
    logic                              o_out_valid;
    logic                              i_out_ready = 1'b0;
    logic                              o_status;
    logic signed [kfli_pkg::POS_W-1:0] o_pos_x;
    logic signed [kfli_pkg::POS_W-1:0] o_pos_y;
    logic                              i_cfg_valid = 1'b0;
    logic                              o_cfg_ready;
    logic [kfli_pkg::CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [kfli_pkg::CFG_W-1:0]        i_cfg_data = '0;

    // traffic control
    t_move_word moves_to_send[$];
    t_pos_word  pending_positions[$];
    t_move_word on_wire;
    int         send_gap_pct = 0;
    int         stall_pct = 0;
    logic       receiver_hold = 1'b0;
    int         words_queued = 0;
    int         words_checked = 0;
    int         mismatch_count = 0;

    // mirror of the block state
    logic signed [kfli_pkg::POS_W-1:0] origin_x = '0;
    logic signed [kfli_pkg::POS_W-1:0] origin_y = '0;
    int unsigned                       key_total = 0;
    logic [kfli_pkg::TICK_W-1:0]       key_begin [KEY_SLOTS];
    logic [kfli_pkg::TICK_W-1:0]       key_len [KEY_SLOTS];
    logic signed [kfli_pkg::POS_W-1:0] key_tx [KEY_SLOTS];
    logic signed [kfli_pkg::POS_W-1:0] key_ty [KEY_SLOTS];

    keyframe_linear_motion_interpolator #(
        .MAX_KEYS(KEY_SLOTS)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_action       (i_action),
        .i_key_start    (i_key_start),
        .i_key_duration (i_key_duration),
        .i_target_x     (i_target_x),
        .i_target_y     (i_target_y),
        .i_query_tick   (i_query_tick),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_pos_x        (o_pos_x),
        .o_pos_y        (o_pos_y),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // clock and reset
    always #5 i_clk = ~i_clk;

    initial begin : reset_gen
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // random values cut to field width
    function automatic logic [kfli_pkg::POS_W-1:0] rand_pos();
        logic [31:0] v;
        v = $urandom;
        return v[kfli_pkg::POS_W-1:0];
    endfunction

    function automatic logic [kfli_pkg::CFG_W-1:0] rand_cfg();
        logic [31:0] v;
        v = $urandom;
        return v[kfli_pkg::CFG_W-1:0];
    endfunction

    function automatic logic [kfli_pkg::ACT_W-1:0] rand_act();
        logic [31:0] v;
        v = $urandom;
        return v[kfli_pkg::ACT_W-1:0];
    endfunction

    // linear step from one point toward another, quotient truncated toward zero
    function automatic logic signed [kfli_pkg::POS_W-1:0] blend_axis(
        input logic signed [kfli_pkg::POS_W-1:0] from_p,
        input logic signed [kfli_pkg::POS_W-1:0] to_p,
        input logic [kfli_pkg::TICK_W-1:0]       elapsed,
        input logic [kfli_pkg::TICK_W-1:0]       span
    );
        longint num;
        longint den;
        longint sum;
        num = (longint'(to_p) - longint'(from_p)) * longint'({32'd0, elapsed});
        den = longint'({32'd0, span});
        sum = longint'(from_p) + num / den;
        return sum[kfli_pkg::POS_W-1:0];
    endfunction

    // applies one word to the mirrored table and returns the result word it gives
    function automatic t_pos_word interpolate_word(input t_move_word w);
        t_pos_word                   r;
        int unsigned                 slot;
        int                          k;
        logic [kfli_pkg::TICK_W:0]   end_tick;
        r.status = kfli_pkg::STS_OK;
        r.pos_x  = '0;
        r.pos_y  = '0;
        case (w.action)
            kfli_pkg::ACT_CLEAR: begin
                key_total = 0;
            end
            kfli_pkg::ACT_LOAD: begin
                if (key_total >= KEY_SLOTS) begin
                    r.status = kfli_pkg::STS_FULL;
                end else begin
                    // move later keyframes up, equal starts stay ahead
                    slot = key_total;
                    while (slot > 0 && key_begin[slot-1] > w.key_start) begin
                        key_begin[slot] = key_begin[slot-1];
                        key_len[slot]   = key_len[slot-1];
                        key_tx[slot]    = key_tx[slot-1];
                        key_ty[slot]    = key_ty[slot-1];
                        slot--;
                    end
                    key_begin[slot] = w.key_start;
                    key_len[slot]   = w.key_duration;
                    key_tx[slot]    = w.target_x;
                    key_ty[slot]    = w.target_y;
                    key_total++;
                end
            end
            kfli_pkg::ACT_QUERY: begin
                r.pos_x = origin_x;
                r.pos_y = origin_y;
                for (k = 0; k < key_total && key_begin[k] <= w.query_tick; k++) begin
                    end_tick = {1'b0, key_begin[k]} + {1'b0, key_len[k]};
                    if ({1'b0, w.query_tick} >= end_tick || key_len[k] == '0) begin
                        r.pos_x = key_tx[k];
                        r.pos_y = key_ty[k];
                    end else begin
                        r.pos_x = blend_axis(r.pos_x, key_tx[k],
                                             w.query_tick - key_begin[k], key_len[k]);
                        r.pos_y = blend_axis(r.pos_y, key_ty[k],
                                             w.query_tick - key_begin[k], key_len[k]);
                    end
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ERROR: %s", $time, msg);
        mismatch_count++;
    endtask

    // input side: offer queued words, mirror each one as it is taken
    always @(posedge i_clk) begin : driver
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                pending_positions = {pending_positions, interpolate_word(on_wire)};
            end
            if (!i_in_valid || o_in_ready) begin
                if (moves_to_send.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    on_wire = moves_to_send.pop_front();
                    i_in_valid     <= 1'b1;
                    i_action       <= on_wire.action;
                    i_key_start    <= on_wire.key_start;
                    i_key_duration <= on_wire.key_duration;
                    i_target_x     <= on_wire.target_x;
                    i_target_y     <= on_wire.target_y;
                    i_query_tick   <= on_wire.query_tick;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // output side: compare each taken word with the oldest outstanding one
    always @(posedge i_clk) begin : monitor
        t_pos_word want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (pending_positions.size() == 0) begin
                    report_mismatch("result word with nothing outstanding");
                end else begin
                    want = pending_positions.pop_front();
                    if (o_status !== want.status)
                        report_mismatch($sformatf("word %0d status got %0b want %0b",
                                                  words_checked, o_status, want.status));
                    if (o_pos_x !== want.pos_x)
                        report_mismatch($sformatf("word %0d pos_x got %0d want %0d",
                                                  words_checked, o_pos_x, want.pos_x));
                    if (o_pos_y !== want.pos_y)
                        report_mismatch($sformatf("word %0d pos_y got %0d want %0d",
                                                  words_checked, o_pos_y, want.pos_y));
                end
                words_checked++;
            end
            i_out_ready <= !receiver_hold && ($urandom_range(99) >= stall_pct);
        end
    end

    // word builders
    function automatic t_move_word noise_word(input logic [kfli_pkg::ACT_W-1:0] act);
        t_move_word w;
        w.action       = act;
        w.key_start    = $urandom;
        w.key_duration = $urandom;
        w.target_x     = rand_pos();
        w.target_y     = rand_pos();
        w.query_tick   = $urandom;
        return w;
    endfunction

    function automatic t_move_word load_word(
        input logic [kfli_pkg::TICK_W-1:0]       start,
        input logic [kfli_pkg::TICK_W-1:0]       span,
        input logic signed [kfli_pkg::POS_W-1:0] tx,
        input logic signed [kfli_pkg::POS_W-1:0] ty
    );
        t_move_word w;
        w = noise_word(kfli_pkg::ACT_LOAD);
        w.key_start    = start;
        w.key_duration = span;
        w.target_x     = tx;
        w.target_y     = ty;
        return w;
    endfunction

    function automatic t_move_word query_word(input logic [kfli_pkg::TICK_W-1:0] tick);
        t_move_word w;
        w = noise_word(kfli_pkg::ACT_QUERY);
        w.query_tick = tick;
        return w;
    endfunction

    function automatic logic signed [kfli_pkg::POS_W-1:0] edge_or_any();
        case ($urandom_range(3))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            default: return rand_pos();
        endcase
    endfunction

    task automatic push_word(input t_move_word w);
        moves_to_send = {moves_to_send, w};
        words_queued++;
    endtask

    // wait until every queued word is taken and every result word has come
    task automatic wait_idle();
        while (moves_to_send.size() != 0 || i_in_valid || pending_positions.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [kfli_pkg::CFG_IDX_W-1:0] idx,
                             input logic [kfli_pkg::CFG_W-1:0]     value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            kfli_pkg::CFG_START_X: origin_x = value;
            kfli_pkg::CFG_START_Y: origin_y = value;
            default: begin
            end
        endcase
        @(negedge i_clk);
    endtask

    task automatic hold_receiver(input int cycles);
        receiver_hold = 1'b1;
        repeat (cycles) @(negedge i_clk);
        receiver_hold = 1'b0;
    endtask

    // a clear in most runs, a run of loads, then queries mostly aimed around the loaded keyframes
    task automatic queue_sequence();
        logic [kfli_pkg::TICK_W-1:0] starts[$];
        logic [kfli_pkg::TICK_W-1:0] spans[$];
        logic [kfli_pkg::TICK_W-1:0] base;
        logic [kfli_pkg::TICK_W-1:0] span;
        t_move_word                  w;
        int                          n_keys;
        int                          n_queries;
        int                          pick;
        int                          k;
        if ($urandom_range(9) != 0) push_word(noise_word(kfli_pkg::ACT_CLEAR));
        pick = $urandom_range(99);
        if (pick < 65)      n_keys = $urandom_range(5, 1);
        else if (pick < 90) n_keys = $urandom_range(15, 6);
        else                n_keys = $urandom_range(18, 16);
        case ($urandom_range(3))
            0: base = $urandom_range(500);
            1: base = $urandom;
            2: base = 32'hFFFF_FFFF - $urandom_range(3000);
            default: base = $urandom_range(100_000);
        endcase
        for (k = 0; k < n_keys; k++) begin
            case ($urandom_range(5))
                0: span = '0;
                1: span = $urandom_range(8, 1);
                2, 3: span = $urandom_range(3000, 1);
                4: span = $urandom;
                default: span = 32'hFFFF_FFFF - $urandom_range(15);
            endcase
            w = load_word(base + $urandom_range(2000), span, edge_or_any(), edge_or_any());
            starts = {starts, w.key_start};
            spans  = {spans, w.key_duration};
            push_word(w);
            if ($urandom_range(19) == 0) push_word(noise_word(rand_act()));
        end
        n_queries = $urandom_range(6, 1);
        for (k = 0; k < n_queries; k++) begin
            pick = $urandom_range(starts.size() - 1);
            case ($urandom_range(7))
                0: w = query_word(starts[pick] - 1);
                1: w = query_word(starts[pick]);
                2: w = query_word(starts[pick] + spans[pick]);
                3: w = query_word(starts[pick] + spans[pick] - 1);
                4: w = noise_word(kfli_pkg::ACT_QUERY);
                5: w = query_word($urandom_range(1) ? 32'hFFFF_FFFF : 32'd0);
                default: w = query_word(starts[pick] + $urandom_range(spans[pick]));
            endcase
            push_word(w);
            if ($urandom_range(24) == 0) push_word(noise_word(rand_act()));
        end
    endtask

    initial begin : stimulus
        int phase;
        int target;
        int k;
        wait (i_rst_n);
        @(negedge i_clk);

        // directed: start point left at its reset value
        push_word(query_word(32'd0));
        push_word(noise_word(ACT_NOP));
        // instant keyframe with extreme targets
        push_word(load_word(32'd100, 32'd0, 16'sh7FFF, 16'sh8000));
        // end tick past 32 bits
        push_word(load_word(32'hFFFF_FF00, 32'h0000_0200, 16'sh8000, 16'sh7FFF));
        // equal start keeps load order
        push_word(load_word(32'd100, 32'd50, 16'sh8000, 16'sh7FFF));
        // earlier start goes to the front
        push_word(load_word(32'd10, 32'd1000, 16'sd1000, -16'sd1000));
        push_word(query_word(32'd5));
        push_word(query_word(32'd125));
        push_word(query_word(32'hFFFF_FFFF));
        for (k = 0; k < 12; k++)
            push_word(load_word(32'd200 + 16 * k, $urandom_range(40, 1),
                                rand_pos(), rand_pos()));
        // table full
        push_word(load_word(32'd300, 32'd5, 16'sd1, 16'sd1));
        push_word(query_word(32'd400));
        push_word(noise_word(kfli_pkg::ACT_CLEAR));
        push_word(query_word(32'hFFFF_FFFF));
        wait_idle();

        // unmapped register index leaves the start point alone
        write_reg(CFG_UNMAPPED, 16'h5A5A);
        push_word(query_word($urandom));
        wait_idle();

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_gap_pct = 0;
                    stall_pct    = 0;
                    write_reg(kfli_pkg::CFG_START_X, 16'h8000);
                    write_reg(kfli_pkg::CFG_START_Y, 16'h7FFF);
                end
                1: begin
                    send_gap_pct = 78;
                    stall_pct    = 0;
                    write_reg(kfli_pkg::CFG_START_X, 16'h7FFF);
                    write_reg(kfli_pkg::CFG_START_Y, 16'h8000);
                end
                2: begin
                    send_gap_pct = 0;
                    stall_pct    = 78;
                    write_reg(kfli_pkg::CFG_START_X, 16'h0000);
                    write_reg(kfli_pkg::CFG_START_Y, 16'h0000);
                end
                default: begin
                    send_gap_pct = 25;
                    stall_pct    = 25;
                    write_reg(kfli_pkg::CFG_START_X, rand_cfg());
                    write_reg(kfli_pkg::CFG_START_Y, rand_cfg());
                end
            endcase
            // long receiver hold-off so the block backs up and stalls its input
            if (phase == 0) begin
                fork
                    hold_receiver(600);
                join_none
            end
            target = words_queued + RANDOM_WORDS_PER_PHASE;
            while (words_queued < target) begin
                queue_sequence();
                // sender pause until the block drains, sometimes with a new start point
                if ($urandom_range(11) == 0) begin
                    wait_idle();
                    if ($urandom_range(1) == 0)
                        write_reg($urandom_range(1) ? kfli_pkg::CFG_START_X
                                                    : kfli_pkg::CFG_START_Y,
                                  rand_cfg());
                end
            end
            wait_idle();
        end

        repeat (64) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // run limit
    initial begin : watchdog
        #100_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/kfli_pkg.sv
hdl/kfli_ram.sv
hdl/kfli_div.sv
hdl/kfli_dp.sv
hdl/kfli_ctrl.sv
hdl/keyframe_linear_motion_interpolator.sv
bench/tb_keyframe_linear_motion_interpolator.sv
